// ----- rtl/rinv_pkg.sv -----
// shared types and constants for the resident id number validator
package rinv_pkg;

  localparam int unsigned CODE_W     = 20;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;

  localparam logic [YEAR_W-1:0] YEAR_MIN_RST = 14'd1900;
  localparam logic [YEAR_W-1:0] YEAR_MAX_RST = 14'd2011;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_CHAR   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    VERDICT_INVALID = 2'd0,
    VERDICT_FEMALE  = 2'd1,
    VERDICT_MALE    = 2'd2
  } verdict_e;

  typedef enum logic {
    REG_YEAR_MIN = 1'b0,
    REG_YEAR_MAX = 1'b1
  } reg_idx_e;

  // one classified item waiting between front and back
  typedef struct packed {
    cmd_e              cmd;
    logic [CODE_W-1:0] region_code;
    logic [3:0]        digit;
    logic              is_digit;
    logic              is_x;
  } entry_t;

  typedef struct packed {
    logic [YEAR_W-1:0] year_min;
    logic [YEAR_W-1:0] year_max;
  } cfg_t;

endpackage

// ----- rtl/rinv_front.sv -----
// front end: accepts stream items, decodes the character and drops unused commands
module rinv_front import rinv_pkg::*; (
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [31:0]       s_axis_tdata_i,
  input  logic [1:0]        s_axis_tuser_i,
  input  logic              fifo_full_i,
  output logic              push_o,
  output entry_t            entry_o
);

  logic [CHAR_W-1:0] ch;
  logic              known_cmd;
  logic              is_digit;

  assign ch       = s_axis_tdata_i[CODE_W +: CHAR_W];
  assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);

  always_comb begin
    unique case (s_axis_tuser_i)
      CMD_CLEAR, CMD_APPEND, CMD_CHAR: known_cmd = 1'b1;
      default:                         known_cmd = 1'b0;
    endcase
  end

  assign s_axis_tready_o = !fifo_full_i;
  assign push_o          = s_axis_tvalid_i && !fifo_full_i && known_cmd;

  always_comb begin
    entry_o             = '0;
    entry_o.cmd         = cmd_e'(s_axis_tuser_i);
    entry_o.region_code = s_axis_tdata_i[CODE_W-1:0];
    entry_o.is_digit    = is_digit;
    entry_o.is_x        = (ch == 8'h58);
    entry_o.digit       = is_digit ? 4'(ch - 8'h30) : 4'd0;
  end

endmodule

// ----- rtl/rinv_fifo.sv -----
// short queue between the front end and the back end
module rinv_fifo import rinv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output entry_t entry_o
);

  entry_t                mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + FIFO_CNT_W'(push_i) - FIFO_CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/rinv_back.sv -----
// back end: region table, per-character id checks and the result register
module rinv_back import rinv_pkg::*; #(
  parameter int unsigned REGION_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        valid_i,
  input  entry_t      entry_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output verdict_e    verdict_o
);

  localparam int unsigned CNT_W = $clog2(REGION_DEPTH + 1);
  localparam int unsigned IDX_W = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;

  localparam logic [4:0] POS_REGION_END = 5'd5;
  localparam logic [4:0] POS_YEAR_0     = 5'd6;
  localparam logic [4:0] POS_YEAR_1     = 5'd7;
  localparam logic [4:0] POS_YEAR_2     = 5'd8;
  localparam logic [4:0] POS_YEAR_END   = 5'd9;
  localparam logic [4:0] POS_MONTH_0    = 5'd10;
  localparam logic [4:0] POS_MONTH_END  = 5'd11;
  localparam logic [4:0] POS_DAY_0      = 5'd12;
  localparam logic [4:0] POS_DAY_END    = 5'd13;
  localparam logic [4:0] POS_SEQ_0      = 5'd14;
  localparam logic [4:0] POS_SEQ_END    = 5'd16;
  localparam logic [4:0] POS_CHECK      = 5'd17;

  function automatic logic [3:0] mod11(input logic [5:0] v);
    logic [5:0] r;
    if (v >= 6'd33)      r = v - 6'd33;
    else if (v >= 6'd22) r = v - 6'd22;
    else if (v >= 6'd11) r = v - 6'd11;
    else                 r = v;
    return r[3:0];
  endfunction

  function automatic logic day_ok(input logic [6:0] month, input logic [6:0] day,
                                  input logic leap);
    logic [4:0] last;
    case (month) inside
      7'd4, 7'd6, 7'd9, 7'd11:                    last = 5'd30;
      7'd2:                                       last = leap ? 5'd29 : 5'd28;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: last = 5'd31;
      default:                                    last = 5'd0;
    endcase
    return (day != 7'd0) && (day <= 7'(last));
  endfunction

  logic [CODE_W-1:0] region_q [REGION_DEPTH];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [4:0]        pos_q, pos_d;
  logic [CODE_W-1:0] field_q, field_d;
  logic [6:0]        month_q, month_d;
  logic [3:0]        resid_q, resid_d;
  logic              inval_q, inval_d;
  logic [1:0]        hi_mod4_q, hi_mod4_d;
  logic [1:0]        lo_mod4_q, lo_mod4_d;
  logic              lo_zero_q, lo_zero_d;
  logic              pend_q, pend_d;
  logic [CODE_W-1:0] pend_code_q, pend_code_d;
  logic              out_valid_q, out_valid_d;
  verdict_e          verdict_q, verdict_d;

  logic                    is_char, is_final, can_pop, do_pop, append_we;
  logic [REGION_DEPTH-1:0] hit;
  logic [CODE_W-1:0]       field_next;
  logic [YEAR_W-1:0]       year;
  logic [4:0]              check_sum;
  logic [3:0]              d;
  logic                    leap;

  // region lookup in the cycle after the sixth digit, against the table as it stands
  always_comb begin
    for (int i = 0; i < REGION_DEPTH; i++) begin
      hit[i] = (CNT_W'(i) < count_q) && (region_q[i] == pend_code_q);
    end
  end

  assign is_char   = (entry_i.cmd == CMD_CHAR);
  assign is_final  = is_char && (pos_q == POS_CHECK);
  assign can_pop   = !is_final || !out_valid_q || out_ready_i;
  assign pop_o     = can_pop;
  assign do_pop    = valid_i && can_pop;
  assign append_we = do_pop && (entry_i.cmd == CMD_APPEND) &&
                     (count_q < CNT_W'(REGION_DEPTH));

  assign d          = entry_i.digit;
  assign field_next = (field_q << 3) + (field_q << 1) + CODE_W'(d);
  assign year       = field_next[YEAR_W-1:0];
  assign check_sum  = 5'(resid_q) + (entry_i.is_x ? 5'd10 : 5'(d));
  assign leap       = lo_zero_q ? (hi_mod4_q == 2'd0) : (lo_mod4_q == 2'd0);

  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    field_d     = field_q;
    month_d     = month_q;
    resid_d     = resid_q;
    inval_d     = inval_q | (pend_q & ~(|hit));
    hi_mod4_d   = hi_mod4_q;
    lo_mod4_d   = lo_mod4_q;
    lo_zero_d   = lo_zero_q;
    pend_d      = 1'b0;
    pend_code_d = pend_code_q;
    out_valid_d = out_valid_q && !out_ready_i;
    verdict_d   = verdict_q;

    if (do_pop) begin
      case (entry_i.cmd)
        CMD_CLEAR: begin
          count_d = '0;
        end
        CMD_APPEND: begin
          if (append_we) begin
            count_d = count_q + 1'b1;
          end
        end
        CMD_CHAR: begin
          if (is_final) begin
            if ((!entry_i.is_digit && !entry_i.is_x) ||
                !((check_sum == 5'd1) || (check_sum == 5'd12)) || inval_q) begin
              verdict_d = VERDICT_INVALID;
            end else begin
              verdict_d = field_q[0] ? VERDICT_MALE : VERDICT_FEMALE;
            end
            out_valid_d = 1'b1;
            pos_d       = '0;
            field_d     = '0;
            month_d     = '0;
            resid_d     = '0;
            inval_d     = 1'b0;
            hi_mod4_d   = '0;
            lo_mod4_d   = '0;
            lo_zero_d   = 1'b0;
          end else begin
            if (!entry_i.is_digit) begin
              inval_d = 1'b1;
            end
            resid_d = mod11({1'b0, check_sum} << 1);
            pos_d   = pos_q + 1'b1;
            if ((pos_q == 5'd0) || (pos_q == POS_YEAR_0) || (pos_q == POS_MONTH_0) ||
                (pos_q == POS_DAY_0) || (pos_q == POS_SEQ_0)) begin
              field_d = CODE_W'(d);
            end else begin
              field_d = field_next;
            end
            // leap rule from the year digits: mod 4 of each digit pair
            case (pos_q)
              POS_REGION_END: begin
                pend_d      = 1'b1;
                pend_code_d = field_next;
              end
              POS_YEAR_0: hi_mod4_d = d[1:0];
              POS_YEAR_1: hi_mod4_d = {hi_mod4_q[0], 1'b0} + d[1:0];
              POS_YEAR_2: begin
                lo_mod4_d = d[1:0];
                lo_zero_d = (d == 4'd0);
              end
              POS_YEAR_END: begin
                lo_mod4_d = {lo_mod4_q[0], 1'b0} + d[1:0];
                lo_zero_d = lo_zero_q && (d == 4'd0);
                if ((year < cfg_i.year_min) || (year > cfg_i.year_max)) begin
                  inval_d = 1'b1;
                end
              end
              POS_MONTH_END: begin
                month_d = field_next[6:0];
                if ((field_next[6:0] < 7'd1) || (field_next[6:0] > 7'd12)) begin
                  inval_d = 1'b1;
                end
              end
              POS_DAY_END: begin
                if (!day_ok(month_q, field_next[6:0], leap)) begin
                  inval_d = 1'b1;
                end
              end
              POS_SEQ_END: begin
                if (field_next == '0) begin
                  inval_d = 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (append_we) begin
      region_q[count_q[IDX_W-1:0]] <= entry_i.region_code;
    end
    pend_code_q <= pend_code_d;
    verdict_q   <= verdict_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      field_q     <= '0;
      month_q     <= '0;
      resid_q     <= '0;
      inval_q     <= 1'b0;
      hi_mod4_q   <= '0;
      lo_mod4_q   <= '0;
      lo_zero_q   <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      pos_q       <= pos_d;
      field_q     <= field_d;
      month_q     <= month_d;
      resid_q     <= resid_d;
      inval_q     <= inval_d;
      hi_mod4_q   <= hi_mod4_d;
      lo_mod4_q   <= lo_mod4_d;
      lo_zero_q   <= lo_zero_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

endmodule

// ----- rtl/resident_id_number_validator_core.sv -----
// top level of the resident id number validator
//
//  channel  | direction | transfer contents
//  ---------+-----------+-----------------------------------------------------
//  s_axis   | in        | tuser: command; tdata: region_code, id_char
//  m_axis   | out       | tdata: verdict, one per 18th id character
//  cfg      | in        | write of year_min (index 0) or year_max (index 1)
//
// one transfer a cycle is taken while the queue has room; a result goes through
// the queue, then the back end, and is held in the result register
// the back end handles one queued item per cycle while it is not stalled; the region
// lookup runs in the cycle after the sixth digit, using the table compare and or-reduce
// a held result stalls only final characters; other items keep draining
// reset clears the table count, id progress, queue and result valid flag
module resident_id_number_validator_core import rinv_pkg::*; #(
  parameter int unsigned REGION_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: region_code [19:0], id_char [27:20], zero [31:28]
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [31:0]           s_axis_tdata_i,
  // tuser: command [1:0]
  input  logic [1:0]            s_axis_tuser_i,
  // tdata: verdict [1:0], zero [7:2]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t     cfg_q;
  entry_t   front_entry, queue_entry;
  logic     push, fifo_full, fifo_valid, pop;
  verdict_e verdict;

  // year bounds
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.year_min <= YEAR_MIN_RST;
      cfg_q.year_max <= YEAR_MAX_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_YEAR_MIN: cfg_q.year_min <= cfg_data_i[YEAR_W-1:0];
        REG_YEAR_MAX: cfg_q.year_max <= cfg_data_i[YEAR_W-1:0];
      endcase
    end
  end

  rinv_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .entry_o         (front_entry)
  );

  rinv_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (fifo_full),
    .valid_o (fifo_valid),
    .pop_i   (pop),
    .entry_o (queue_entry)
  );

  rinv_back #(
    .REGION_DEPTH (REGION_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .valid_i     (fifo_valid),
    .entry_i     (queue_entry),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .verdict_o   (verdict)
  );

  assign m_axis_tdata_o = {6'd0, verdict};

endmodule

// ----- rtl/rinv_checker.sv -----
// port-level checks for the validator, bound to the top level
module rinv_checker import rinv_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [31:0]           s_axis_tdata_i,
  input logic [1:0]            s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [7:0]            m_axis_tdata_o,
  input logic                  cfg_we_i,
  input logic                  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  // a stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // no result in the cycle after reset is sampled asserted
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  // padding above the verdict stays zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:2] == 6'd0)
    else $error("result padding not zero");

  // a result never rises straight out of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> !$past(!rst_ni))
    else $error("result right out of reset");

endmodule

bind resident_id_number_validator_core rinv_checker u_rinv_checker (.*);

// ----- dv/rinv_verdict_checker.sv -----
// verdict checker for the resident id number validator: predicts and compares
`timescale 1ns / 1ps
module rinv_verdict_checker import rinv_pkg::*; #(
  parameter int unsigned REGION_DEPTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  // tdata: region_code [19:0], id_char [27:20], zero [31:28]
  input  logic [31:0]           s_axis_tdata_i,
  // tuser: command [1:0]
  input  logic [1:0]            s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  // tdata: verdict [1:0], zero [7:2]
  input  logic [7:0]            m_axis_tdata_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  localparam int unsigned REPORT_CAP = 50;

  // character positions inside one id
  localparam logic [4:0] POS_REGION_LAST = 5'd5;
  localparam logic [4:0] POS_YEAR_FIRST  = 5'd6;
  localparam logic [4:0] POS_YEAR_LAST   = 5'd9;
  localparam logic [4:0] POS_MONTH_FIRST = 5'd10;
  localparam logic [4:0] POS_MONTH_LAST  = 5'd11;
  localparam logic [4:0] POS_DAY_FIRST   = 5'd12;
  localparam logic [4:0] POS_DAY_LAST    = 5'd13;
  localparam logic [4:0] POS_SEQ_FIRST   = 5'd14;
  localparam logic [4:0] POS_SEQ_LAST    = 5'd16;
  localparam logic [4:0] POS_CHECK       = 5'd17;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_X    = 8'h58;

  logic [YEAR_W-1:0] year_lo;
  logic [YEAR_W-1:0] year_hi;
  logic [CODE_W-1:0] region_mem [REGION_DEPTH];
  int unsigned       region_fill;
  logic [4:0]        char_pos;
  logic [CODE_W-1:0] field_acc;
  logic [YEAR_W-1:0] year_seen;
  logic [6:0]        month_seen;
  logic [3:0]        mod11_acc;
  logic              id_bad;
  verdict_e          expected_verdicts [$];
  verdict_e          oldest_verdict;

  task automatic report_mismatch(input string msg);
    if (fail_count_o < REPORT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic logic [4:0] days_in_month(logic [YEAR_W-1:0] yr, logic [6:0] mo);
    logic leap;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    case (mo)
      7'd4, 7'd6, 7'd9, 7'd11:                     return 5'd30;
      7'd2:                                        return leap ? 5'd29 : 5'd28;
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: return 5'd31;
      default:                                     return 5'd0;
    endcase
  endfunction

  function automatic void restart_id();
    char_pos   = '0;
    field_acc  = '0;
    year_seen  = '0;
    month_seen = '0;
    mod11_acc  = '0;
    id_bad     = 1'b0;
  endfunction

  // advances the model by one accepted transfer, queues a verdict on the last character
  function automatic void predict_verdict(logic [1:0] cmd, logic [CODE_W-1:0] code,
                                          logic [7:0] ch);
    logic       dig;
    logic [3:0] d;
    logic [4:0] p;
    logic       hit;
    case (cmd)
      CMD_CLEAR: region_fill = 0;
      CMD_APPEND: begin
        if (region_fill < REGION_DEPTH) begin
          region_mem[region_fill] = code;
          region_fill++;
        end
      end
      CMD_CHAR: begin
        p   = char_pos;
        dig = (ch >= ASCII_ZERO) && (ch <= ASCII_NINE);
        d   = dig ? 4'(ch - ASCII_ZERO) : 4'd0;
        if (p == POS_CHECK) begin
          if (ch == ASCII_X) d = 4'd10;
          else if (!dig) id_bad = 1'b1;
          if ((mod11_acc + d) % 11 != 1) id_bad = 1'b1;
          if (id_bad) expected_verdicts.push_back(VERDICT_INVALID);
          else expected_verdicts.push_back(field_acc[0] ? VERDICT_MALE : VERDICT_FEMALE);
          restart_id();
        end else begin
          if (!dig) id_bad = 1'b1;
          mod11_acc = 4'(((mod11_acc + d) * 2) % 11);
          case (p)
            5'd0, POS_YEAR_FIRST, POS_MONTH_FIRST, POS_DAY_FIRST, POS_SEQ_FIRST:
              field_acc = CODE_W'(d);
            default: field_acc = CODE_W'(field_acc * 10 + d);
          endcase
          case (p)
            POS_REGION_LAST: begin
              hit = 1'b0;
              for (int i = 0; i < region_fill; i++) if (region_mem[i] == field_acc) hit = 1'b1;
              if (!hit) id_bad = 1'b1;
            end
            POS_YEAR_LAST: begin
              year_seen = field_acc[YEAR_W-1:0];
              if (year_seen < year_lo || year_seen > year_hi) id_bad = 1'b1;
            end
            POS_MONTH_LAST: begin
              month_seen = field_acc[6:0];
              if (month_seen < 1 || month_seen > 12) id_bad = 1'b1;
            end
            POS_DAY_LAST: begin
              if (field_acc < 1 || field_acc > days_in_month(year_seen, month_seen))
                id_bad = 1'b1;
            end
            POS_SEQ_LAST: if (field_acc == 0) id_bad = 1'b1;
            default: ;
          endcase
          char_pos = p + 5'd1;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_lo     = YEAR_MIN_RST;
      year_hi     = YEAR_MAX_RST;
      region_fill = 0;
      restart_id();
      expected_verdicts.delete();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_YEAR_MIN) year_lo = cfg_data_i;
        else year_hi = cfg_data_i;
      end
      // results first: a verdict never leaves in the cycle its last character arrives
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("verdict transfer with none expected, tdata=%h",
                                    m_axis_tdata_i));
        end else begin
          oldest_verdict = expected_verdicts.pop_front();
          if (m_axis_tdata_i[1:0] !== oldest_verdict)
            report_mismatch($sformatf("verdict %0d, expected %0d",
                                      m_axis_tdata_i[1:0], oldest_verdict));
          if (m_axis_tdata_i[7:2] !== '0)
            report_mismatch($sformatf("tdata padding %h not zero", m_axis_tdata_i[7:2]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i)
        predict_verdict(s_axis_tuser_i, s_axis_tdata_i[CODE_W-1:0],
                        s_axis_tdata_i[CODE_W+CHAR_W-1:CODE_W]);
    end
    pending_o = expected_verdicts.size();
  end

endmodule

// ----- dv/tb_resident_id_number_validator_core.sv -----
// testbench top for the resident id number validator core
`timescale 1ns / 1ps
module tb_resident_id_number_validator_core;
  import rinv_pkg::*;

  localparam int unsigned REGION_DEPTH = 32;
  localparam int unsigned ID_LEN       = 18;
  localparam int unsigned ITEM_GOAL    = 1900;
  localparam int unsigned IDS_PER_PHASE = 8;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned HOLD_PHASE   = 3;
  localparam int unsigned FULL_PHASE   = 2;
  localparam int unsigned DRAIN_SETTLE = 8;    // covers the registered result path and the queue
  localparam int unsigned END_SETTLE   = 20;
  localparam int unsigned CODE_MAX     = 999999;
  localparam int unsigned YEAR_TOP     = 9999;

  // command value the block leaves alone
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_NINE    = 8'h39;
  localparam logic [7:0] ASCII_X       = 8'h58;
  localparam logic [7:0] ASCII_LOWER_X = 8'h78;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [31:0]           s_axis_tdata_i  = '0;
  logic [1:0]            s_axis_tuser_i  = CMD_CLEAR;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [7:0]            m_axis_tdata_o;
  logic                  cfg_we_i        = 1'b0;
  logic                  cfg_idx_i       = REG_YEAR_MIN;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;

  int unsigned fail_count;
  int unsigned verdicts_pending;

  // stimulus-side bookkeeping
  int unsigned       item_count = 0;
  logic              src_quiet  = 1'b0;  // sender offers back to back
  logic              sink_quiet = 1'b0;  // receiver adds no random stalls
  logic              hold_req   = 1'b0;  // asks the receiver for its long hold-off
  logic [YEAR_W-1:0] year_lo_now = YEAR_MIN_RST;
  logic [YEAR_W-1:0] year_hi_now = YEAR_MAX_RST;
  logic [CODE_W-1:0] region_list [$];    // what the block's table should hold
  logic [7:0]        id_chars [ID_LEN];  // next id to send

  always #5 clk_i = ~clk_i;

  resident_id_number_validator_core #(
    .REGION_DEPTH(REGION_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  rinv_verdict_checker #(
    .REGION_DEPTH(REGION_DEPTH)
  ) u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_i(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_i(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_i (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (verdicts_pending)
  );

  // idle length: mostly none, often short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // receiver: random stalls, quiet stretches, and one long hold-off on request
  initial begin : sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req <= 1'b0;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (!sink_quiet) stall_left = pick_gap();
      end
    end
  end

  // one input transfer; tready is looked at on the falling edge, where it is settled
  // for the coming rising edge, so the handshake never hinges on event order
  task automatic send_item(input logic [1:0] cmd, input logic [CODE_W-1:0] code,
                           input logic [7:0] ch);
    int unsigned gap;
    logic        took;
    gap = src_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {4'b0, ch, code};
    do begin
      @(negedge clk_i);
      took = s_axis_tready_o;
      @(posedge clk_i);
    end while (!took);
    if (cmd != CMD_RESERVED) item_count++;
  endtask

  task automatic clear_regions();
    send_item(CMD_CLEAR, CODE_W'($urandom), 8'($urandom));
    region_list.delete();
  endtask

  // appends beyond the table depth are dropped by the block, so the mirror stops too
  task automatic append_region(input logic [CODE_W-1:0] code);
    send_item(CMD_APPEND, code, 8'($urandom));
    if (region_list.size() < REGION_DEPTH) region_list.push_back(code);
  endtask

  // drop valid, wait for every verdict, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (verdicts_pending != 0);
    repeat (DRAIN_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_years(input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_YEAR_MIN;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= REG_YEAR_MAX;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    year_lo_now = lo;
    year_hi_now = hi;
  endtask

  function automatic void put_decimal(int unsigned first, int unsigned len, int unsigned v);
    for (int k = len - 1; k >= 0; k--) begin
      id_chars[first + k] = 8'(ASCII_ZERO + v % 10);
      v = v / 10;
    end
  endfunction

  // lays out region, birth date and sequence, then appends the mod 11-2 check char
  function automatic void compose_id(int unsigned region, int unsigned yr, int unsigned mo,
                                     int unsigned dy, int unsigned seq);
    int unsigned r;
    int unsigned c;
    put_decimal(0, 6, region);
    put_decimal(6, 4, yr);
    put_decimal(10, 2, mo);
    put_decimal(12, 2, dy);
    put_decimal(14, 3, seq);
    r = 0;
    for (int i = 0; i < ID_LEN - 1; i++) r = ((r + (id_chars[i] - ASCII_ZERO)) * 2) % 11;
    c = (12 - r) % 11;
    id_chars[ID_LEN-1] = (c == 10) ? ASCII_X : 8'(ASCII_ZERO + c);
  endfunction

  // a well-formed id with random content; now and then one field or char is spoiled
  function automatic void make_random_id();
    int unsigned region;
    int unsigned yr;
    int unsigned mo;
    int unsigned dy;
    int unsigned seq;
    int unsigned r;
    int unsigned at;
    if (region_list.size() > 0 && $urandom_range(0, 9) != 0)
      region = region_list[$urandom_range(0, region_list.size() - 1)];
    else
      region = $urandom_range(0, CODE_MAX);
    r = $urandom_range(0, 9);
    if (r == 0) begin
      yr = $urandom_range(0, YEAR_TOP);
    end else if (r == 1) begin
      // century and leap corners for february
      case ($urandom_range(0, 3))
        0:       yr = 1900;
        1:       yr = 2000;
        2:       yr = 2004;
        default: yr = 2100;
      endcase
    end else if (year_lo_now <= year_hi_now) begin
      yr = $urandom_range(year_lo_now, year_hi_now);
    end else begin
      yr = $urandom_range(0, YEAR_TOP);
    end
    if ($urandom_range(0, 9) != 0) mo = $urandom_range(1, 12);
    else mo = $urandom_range(0, 1) ? 0 : $urandom_range(13, 99);
    r = $urandom_range(0, 9);
    if (mo == 2 && $urandom_range(0, 1)) dy = $urandom_range(28, 30);
    else if (r < 7) dy = $urandom_range(1, 28);
    else if (r < 9) dy = $urandom_range(29, 31);
    else dy = $urandom_range(0, 1) ? 0 : $urandom_range(32, 99);
    seq = ($urandom_range(0, 14) == 0) ? 0 : $urandom_range(1, 999);
    compose_id(region, yr, mo, dy, seq);
    if ($urandom_range(0, 4) == 0) begin
      at = $urandom_range(0, ID_LEN - 1);
      case ($urandom_range(0, 4))
        0: id_chars[at] = 8'(ASCII_ZERO + $urandom_range(0, 9));
        1: id_chars[at] = 8'($urandom);
        2: id_chars[ID_LEN-1] = ASCII_LOWER_X;
        3: id_chars[$urandom_range(0, ID_LEN - 2)] = ASCII_X;  // only legal as check char
        default: begin
          if (id_chars[ID_LEN-1] == ASCII_X) id_chars[ID_LEN-1] = ASCII_ZERO;
          else if (id_chars[ID_LEN-1] == ASCII_NINE) id_chars[ID_LEN-1] = ASCII_X;
          else id_chars[ID_LEN-1] = id_chars[ID_LEN-1] + 8'd1;
        end
      endcase
    end
  endfunction

  // sends id_chars, with table commands and the reserved command slipped in between
  task automatic send_id();
    int unsigned r;
    for (int i = 0; i < ID_LEN; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        r = $urandom_range(0, 39);
        if (r == 0) clear_regions();
        else if (r < 6) send_item(CMD_RESERVED, CODE_W'($urandom), 8'($urandom));
        else append_region(CODE_W'($urandom_range(0, CODE_MAX)));
      end
      send_item(CMD_CHAR, CODE_W'($urandom), id_chars[i]);
    end
  endtask

  // a valid prefix followed by junk, still 18 chars so later ids stay aligned
  task automatic send_broken_id();
    int unsigned keep;
    make_random_id();
    keep = $urandom_range(0, ID_LEN - 1);
    for (int i = keep; i < ID_LEN; i++)
      id_chars[i] = $urandom_range(0, 1) ? 8'($urandom)
                                         : 8'(ASCII_ZERO + $urandom_range(0, 9));
    send_id();
  endtask

  // main stimulus
  initial begin : stimulus
    int unsigned       phase;
    int unsigned       n_regions;
    int unsigned       seq;
    logic [YEAR_W-1:0] lo;
    logic [YEAR_W-1:0] hi;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: table extremes, the reserved command, and a leap-day id ending in X
    src_quiet = 1'b1;
    clear_regions();
    append_region(CODE_W'(0));
    append_region(CODE_W'(CODE_MAX));
    append_region(CODE_W'(524288));
    send_item(CMD_RESERVED, '1, 8'hFF);
    seq = 1;
    compose_id(CODE_MAX, 2000, 2, 29, seq);
    while (id_chars[ID_LEN-1] != ASCII_X) begin
      seq++;
      compose_id(CODE_MAX, 2000, 2, 29, seq);
    end
    send_id();

    // random phases: each one drains, retunes the year window, maybe reloads the table
    phase = 0;
    while (item_count < ITEM_GOAL) begin
      wait_idle();
      if (phase > 0) begin
        case (phase % 6)
          1: begin lo = '0; hi = YEAR_W'(YEAR_TOP); end
          2: begin lo = YEAR_W'(YEAR_TOP); hi = '0; end  // empty window rejects every year
          3: begin lo = YEAR_W'(2000); hi = YEAR_W'(2000); end
          4: begin lo = YEAR_MIN_RST; hi = YEAR_MAX_RST; end
          default: begin
            lo = YEAR_W'($urandom_range(0, YEAR_TOP));
            hi = ($urandom_range(0, 7) == 0) ? YEAR_W'($urandom_range(0, YEAR_TOP))
                                             : YEAR_W'($urandom_range(lo, YEAR_TOP));
          end
        endcase
        write_years(lo, hi);
      end
      src_quiet  = ($urandom_range(0, 3) == 0);
      sink_quiet = ($urandom_range(0, 3) == 0);
      if (phase == FULL_PHASE || phase == 1 || $urandom_range(0, 2) == 0) begin
        clear_regions();
        if (phase == FULL_PHASE) n_regions = REGION_DEPTH + 3;  // overflow is dropped
        else if ($urandom_range(0, 9) == 0) n_regions = 0;
        else n_regions = $urandom_range(1, 10);
        repeat (n_regions) append_region(CODE_W'($urandom_range(0, CODE_MAX)));
      end
      if (phase == HOLD_PHASE) begin
        // receiver stalls for a long time while ids keep coming, so the block backs up
        src_quiet = 1'b1;
        hold_req <= 1'b1;
      end
      repeat (IDS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 80) begin
          make_random_id();
          send_id();
        end else begin
          send_broken_id();
        end
      end
      phase++;
    end

    // end of run: everything out, then a little slack for stray transfers
    s_axis_tvalid_i <= 1'b0;
    do @(negedge clk_i); while (verdicts_pending != 0);
    repeat (END_SETTLE) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rinv_pkg.sv
rtl/rinv_front.sv
rtl/rinv_fifo.sv
rtl/rinv_back.sv
rtl/resident_id_number_validator_core.sv
rtl/rinv_checker.sv
dv/rinv_verdict_checker.sv
dv/tb_resident_id_number_validator_core.sv
